### rtl/rict_pkg.sv
`timescale 1ns / 1ps

package rict_pkg;

    // tree shape
    localparam int LEAVES      = 1024;
    localparam int VALUE_RANGE = 40;
    localparam int TREE_W      = 1024;
    localparam int NODE_W      = 11;
    localparam int HNODE_W     = 12;
    localparam int BIN_W       = 6;
    localparam int STEP_W      = 6;
    localparam int CNT_W       = 11;
    localparam int INV_W       = 20;
    localparam int OUT_W       = 19;
    localparam int POS_W       = 10;

    // scratch histograms kept behind the tree nodes
    localparam int ACC_L_NODE  = 2047;
    localparam int ACC_R_NODE  = 2048;
    localparam int HIST_DEPTH  = (ACC_R_NODE + 1) * 64;
    localparam int HIST_AW     = HNODE_W + BIN_W;
    localparam int INV_DEPTH   = 2048;

    // last step of a merge pass
    localparam int PASS_LAST   = VALUE_RANGE + 1;

    // merge pass modes
    localparam logic [2:0] MODE_LEAF  = 3'd0;
    localparam logic [2:0] MODE_SET   = 3'd1;
    localparam logic [2:0] MODE_LEFT  = 3'd2;
    localparam logic [2:0] MODE_RIGHT = 3'd3;
    localparam logic [2:0] MODE_FINAL = 3'd4;

    typedef struct packed {
        logic              start;
        logic              qinit;
        logic [2:0]        mode;
        logic [NODE_W-1:0] node;
        logic [BIN_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [INV_W-1:0] result;
    } t_sts;

endpackage

### rtl/range_inversion_count_tree_core.sv
`timescale 1ns / 1ps

// Range inversion counter over 1024 positions holding values 1 to 40.
// Input channel (i_valid / o_ready): i_kind 0 is a set request that writes
// i_value at i_position (value 0 or above 40 empties it, positions past the
// array are ignored); i_kind 1 is a query request over i_left_end..i_right_end.
// Output channel (o_valid / i_ready): one result per query request,
// o_inversions (low 19 bits of the count) and o_range_error (left > right).
// A set request or a query over a non-empty range is handled as a series of
// merge passes over the 40 histogram bins on one shared datapath; a pass reads
// one bin a cycle from the histogram memory, plus read and commit.
// A set request runs 11 passes; a query runs up to two passes per tree level
// plus one final pass. Reversed or empty ranges answer without a merge pass.
// One request is worked at a time.
// After reset the histogram memory is swept to zero, one entry a cycle, over
// all 131136 entries, during which o_ready stays low.
// A finished result waits in the output register; a new request is accepted
// meanwhile, and a following query holds its result until the first is taken.
module range_inversion_count_tree_core import rict_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_kind,
    input  logic [POS_W-1:0] i_position,
    input  logic [BIN_W-1:0] i_value,
    input  logic [POS_W-1:0] i_left_end,
    input  logic [POS_W-1:0] i_right_end,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_inversions,
    output logic             o_range_error
);

    t_cmd cmd;
    t_sts sts;

    // tree walk controller
    rict_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_position    (i_position),
        .i_value       (i_value),
        .i_left_end    (i_left_end),
        .i_right_end   (i_right_end),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_inversions  (o_inversions),
        .o_range_error (o_range_error),
        .o_cmd         (cmd),
        .i_sts         (sts)
    );

    // histogram merge datapath
    rict_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

### rtl/rict_dp.sv
`timescale 1ns / 1ps

module rict_dp import rict_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    output t_sts o_sts
);

    // histogram and inversion stores
    logic [CNT_W-1:0] r_hist [0:HIST_DEPTH-1];
    logic [INV_W-1:0] r_invm [0:INV_DEPTH-1];

    logic                r_clearing;
    logic [HIST_AW-1:0]  r_clr_addr;
    logic                r_busy;
    logic [STEP_W-1:0]   r_step;
    logic [2:0]          r_mode;
    logic [NODE_W-1:0]   r_node;
    logic [BIN_W-1:0]    r_value;
    logic [CNT_W-1:0]    r_ha, r_hb;
    logic                r_dv;
    logic [BIN_W-1:0]    r_dv_idx;
    logic [INV_W-1:0]    r_ia, r_ib;
    logic [INV_W-1:0]    r_cross;
    logic [CNT_W-1:0]    r_below;
    logic [INV_W-1:0]    r_inv_l, r_inv_r, r_result;
    logic                r_l_init, r_r_init;

    logic [NODE_W:0]     lc_w, rc_w;
    logic [NODE_W-1:0]   lc, rc, ia, ib;
    logic [HNODE_W-1:0]  ha_node, hb_node, d_node;
    logic [BIN_W-1:0]    v;
    logic                rd_issue, a_zero, b_zero, has_dest, done;
    logic [CNT_W-1:0]    a_val, b_val;
    logic [2*CNT_W-1:0]  prod;
    logic [BIN_W:0]      bin_val;
    logic                h_we;
    logic [HIST_AW-1:0]  h_wa;
    logic [CNT_W-1:0]    h_wd;

    // operand addressing per mode
    always_comb begin
        lc_w     = {r_node, 1'b1};
        rc_w     = {r_node, 1'b0} + (NODE_W+1)'(2);
        lc       = lc_w[NODE_W-1:0];
        rc       = rc_w[NODE_W-1:0];
        v        = r_step[BIN_W-1:0];
        rd_issue = r_busy && (r_step < STEP_W'(VALUE_RANGE));
        done     = r_busy && (r_step == STEP_W'(PASS_LAST));
        ha_node  = HNODE_W'(r_node);
        hb_node  = HNODE_W'(r_node);
        d_node   = HNODE_W'(r_node);
        ia       = r_node;
        ib       = r_node;
        has_dest = 1'b1;
        case (r_mode)
            MODE_SET: begin
                ha_node = HNODE_W'(lc);
                hb_node = HNODE_W'(rc);
                ia      = lc;
                ib      = rc;
            end
            MODE_LEFT: begin
                ha_node = HNODE_W'(ACC_L_NODE);
                d_node  = HNODE_W'(ACC_L_NODE);
            end
            MODE_RIGHT: begin
                hb_node = HNODE_W'(ACC_R_NODE);
                d_node  = HNODE_W'(ACC_R_NODE);
            end
            MODE_FINAL: begin
                ha_node  = HNODE_W'(ACC_L_NODE);
                hb_node  = HNODE_W'(ACC_R_NODE);
                has_dest = 1'b0;
            end
            default: ;
        endcase
        a_zero = ((r_mode == MODE_LEFT) || (r_mode == MODE_FINAL)) && !r_l_init;
        b_zero = ((r_mode == MODE_RIGHT) || (r_mode == MODE_FINAL)) && !r_r_init;
        a_val  = a_zero ? '0 : r_ha;
        b_val  = b_zero ? '0 : r_hb;
        prod   = a_val * r_below;
        bin_val = {1'b0, r_dv_idx} + (BIN_W+1)'(1);
    end

    // histogram write port
    always_comb begin
        h_we = 1'b0;
        h_wa = {d_node, r_dv_idx};
        h_wd = a_val + b_val;
        if (r_clearing) begin
            h_we = 1'b1;
            h_wa = r_clr_addr;
            h_wd = '0;
        end else if (r_dv && has_dest) begin
            h_we = 1'b1;
            if (r_mode == MODE_LEAF) begin
                h_wd = (bin_val == {1'b0, r_value}) ? CNT_W'(1) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            r_hist[h_wa] <= h_wd;
        end
        r_ha <= r_hist[{ha_node, v}];
        r_hb <= r_hist[{hb_node, v}];
    end

    // inversion store
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_invm[r_clr_addr[NODE_W-1:0]] <= '0;
        end else if (done && (r_mode == MODE_SET)) begin
            r_invm[r_node] <= r_ia + r_ib + r_cross;
        end else if (done && (r_mode == MODE_LEAF)) begin
            r_invm[r_node] <= '0;
        end
        if (r_busy && (r_step == '0)) begin
            r_ia <= r_invm[ia];
            r_ib <= r_invm[ib];
        end
    end

    // pass sequencing, accumulation and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_busy     <= 1'b0;
            r_step     <= '0;
            r_dv       <= 1'b0;
            r_l_init   <= 1'b0;
            r_r_init   <= 1'b0;
        end else begin
            if (r_clearing) begin
                if (r_clr_addr == HIST_AW'(HIST_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + HIST_AW'(1);
            end
            r_dv     <= rd_issue;
            r_dv_idx <= v;
            if (r_dv) begin
                r_cross <= r_cross + prod[INV_W-1:0];
                r_below <= r_below + b_val;
            end
            if (done) begin
                r_busy <= 1'b0;
                case (r_mode)
                    MODE_LEFT: begin
                        r_inv_l  <= r_inv_l + r_ib + r_cross;
                        r_l_init <= 1'b1;
                    end
                    MODE_RIGHT: begin
                        r_inv_r  <= r_ia + r_inv_r + r_cross;
                        r_r_init <= 1'b1;
                    end
                    MODE_FINAL: r_result <= r_inv_l + r_inv_r + r_cross;
                    default: ;
                endcase
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (i_cmd.qinit) begin
                r_inv_l  <= '0;
                r_inv_r  <= '0;
                r_l_init <= 1'b0;
                r_r_init <= 1'b0;
            end
            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_step  <= '0;
                r_mode  <= i_cmd.mode;
                r_node  <= i_cmd.node;
                r_value <= i_cmd.value;
                r_cross <= '0;
                r_below <= '0;
            end
        end
    end

    assign o_sts.busy   = r_busy || r_clearing;
    assign o_sts.done   = done;
    assign o_sts.result = r_result;

endmodule

### rtl/rict_ctrl.sv
`timescale 1ns / 1ps

module rict_ctrl import rict_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_kind,
    input  logic [POS_W-1:0] i_position,
    input  logic [BIN_W-1:0] i_value,
    input  logic [POS_W-1:0] i_left_end,
    input  logic [POS_W-1:0] i_right_end,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_inversions,
    output logic             o_range_error,
    output t_cmd             o_cmd,
    input  t_sts             i_sts
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_LEAF   = 4'd2;
    localparam logic [3:0] S_UP     = 4'd3;
    localparam logic [3:0] S_QCHK   = 4'd4;
    localparam logic [3:0] S_QL     = 4'd5;
    localparam logic [3:0] S_QRCHK  = 4'd6;
    localparam logic [3:0] S_QR     = 4'd7;
    localparam logic [3:0] S_QF     = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [NODE_W-1:0] r_node, n_node, r_l, n_l, r_r, n_r;
    logic              r_zero, n_zero, r_err, n_err;
    logic              r_ov, n_ov, r_oerr, n_oerr;
    logic [OUT_W-1:0]  r_oinv, n_oinv;
    logic [NODE_W-1:0] up_node, leaf, le_w, re_w, re_c, r_dec;

    always_comb begin
        up_node = (r_node - NODE_W'(1)) >> 1;
        r_dec   = r_r - NODE_W'(1);
        leaf    = NODE_W'(i_position) + NODE_W'(TREE_W - 1);
        le_w    = NODE_W'(i_left_end);
        re_w    = NODE_W'(i_right_end);
        re_c    = (re_w >= NODE_W'(LEAVES)) ? NODE_W'(LEAVES - 1) : re_w;
    end

    // walk the tree, one merge pass at a time
    always_comb begin
        n_state = r_state;
        n_node  = r_node;
        n_l     = r_l;
        n_r     = r_r;
        n_zero  = r_zero;
        n_err   = r_err;
        n_ov    = r_ov && !i_ready;
        n_oerr  = r_oerr;
        n_oinv  = r_oinv;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                if (!i_sts.busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    if (!i_kind) begin
                        if (NODE_W'(i_position) < NODE_W'(LEAVES)) begin
                            o_cmd.start = 1'b1;
                            o_cmd.mode  = MODE_LEAF;
                            o_cmd.node  = leaf;
                            o_cmd.value = i_value;
                            n_node      = leaf;
                            n_state     = S_LEAF;
                        end
                    end else if (le_w > re_w) begin
                        n_zero  = 1'b1;
                        n_err   = 1'b1;
                        n_state = S_OUT;
                    end else if (le_w > re_c) begin
                        n_zero  = 1'b1;
                        n_err   = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        o_cmd.qinit = 1'b1;
                        n_l     = le_w + NODE_W'(TREE_W - 1);
                        n_r     = re_c + NODE_W'(TREE_W);
                        n_zero  = 1'b0;
                        n_err   = 1'b0;
                        n_state = S_QCHK;
                    end
                end
            end
            S_LEAF, S_UP: begin
                if (i_sts.done) begin
                    if (r_node == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.start = 1'b1;
                        o_cmd.mode  = MODE_SET;
                        o_cmd.node  = up_node;
                        n_node      = up_node;
                        n_state     = S_UP;
                    end
                end
            end
            S_QCHK: begin
                if (r_l < r_r) begin
                    if (!r_l[0]) begin
                        o_cmd.start = 1'b1;
                        o_cmd.mode  = MODE_LEFT;
                        o_cmd.node  = r_l;
                        n_state     = S_QL;
                    end else begin
                        n_state = S_QRCHK;
                    end
                end else begin
                    o_cmd.start = 1'b1;
                    o_cmd.mode  = MODE_FINAL;
                    n_state     = S_QF;
                end
            end
            S_QL: begin
                if (i_sts.done) begin
                    n_state = S_QRCHK;
                end
            end
            S_QRCHK: begin
                if (!r_r[0]) begin
                    o_cmd.start = 1'b1;
                    o_cmd.mode  = MODE_RIGHT;
                    o_cmd.node  = r_dec;
                    n_state     = S_QR;
                end else begin
                    n_l     = r_l >> 1;
                    n_r     = r_dec >> 1;
                    n_state = S_QCHK;
                end
            end
            S_QR: begin
                if (i_sts.done) begin
                    n_l     = r_l >> 1;
                    n_r     = r_dec >> 1;
                    n_state = S_QCHK;
                end
            end
            S_QF: begin
                if (i_sts.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || i_ready) begin
                    n_ov    = 1'b1;
                    n_oerr  = r_err;
                    n_oinv  = r_zero ? '0 : i_sts.result[OUT_W-1:0];
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_node <= n_node;
        r_l    <= n_l;
        r_r    <= n_r;
        r_zero <= n_zero;
        r_err  <= n_err;
        r_oerr <= n_oerr;
        r_oinv <= n_oinv;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ov;
    assign o_inversions  = r_oinv;
    assign o_range_error = r_oerr;

    // a pass is only started once the previous one has finished
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> (!i_sts.busy || i_sts.done))
        else $error("merge pass started while datapath busy");

    // requests are only taken with the datapath at rest
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_sts.busy)
        else $error("idle with datapath busy");

    // a fresh result comes only from the output state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_ov && !r_ov) |-> (r_state == S_OUT))
        else $error("result raised outside output state");

    // query setup never coincides with a pass start
    a_qinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.qinit |-> !o_cmd.start)
        else $error("query setup overlaps pass start");

endmodule
